@@ rtl/core/assert_macros.svh @@
// assertion macros used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, masked while reset is asserted
`define DIDS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dids assertion failed");

// checked property, evaluated at every edge including reset
`define DIDS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dids assertion failed");

`else

`define DIDS_ASSERT_RST(lbl, clk, rst_n, prop)
`define DIDS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/dids_pkg.sv @@
// shared types, codes and helper functions of the display idle controller
`timescale 1ns / 1ps

package dids_pkg;

    typedef enum logic [1:0] {
        MODE_AWAKE  = 2'd0,
        MODE_DIMMED = 2'd1,
        MODE_ASLEEP = 2'd2
    } t_mode;

    // request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_ACTIVITY = 3'd1;
    localparam logic [2:0] REQ_BUTTON   = 3'd2;
    localparam logic [2:0] REQ_SET      = 3'd3;
    localparam logic [2:0] REQ_OFF      = 3'd4;

    // register indexes (byte address is 4 * index)
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_DIM_TIMEOUT   = 3'd0;
    localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_DIM_ENABLE    = 3'd2;
    localparam logic [2:0] REG_SLEEP_ENABLE  = 3'd3;
    localparam logic [2:0] REG_DIM_LEVEL     = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE      = 3'd5;

    // reset values
    localparam logic [15:0] RST_DIM_TIMEOUT   = 16'd30;
    localparam logic [15:0] RST_SLEEP_TIMEOUT = 16'd60;
    localparam logic        RST_DIM_ENABLE    = 1'b1;
    localparam logic        RST_SLEEP_ENABLE  = 1'b1;
    localparam logic [6:0]  RST_DIM_LEVEL     = 7'd15;
    localparam logic [15:0] RST_DEBOUNCE      = 16'd50;
    localparam logic [6:0]  RST_SAVED_PCT     = 7'd35;

    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    // 255 * 2^19 / 100 rounded up, exact for every percent up to 100
    localparam logic [27:0] RAW_RECIP = 28'd1336935;
    localparam int unsigned RAW_SHIFT = 19;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [7:0]  percent;
    } t_req;

    typedef struct packed {
        logic        brightness_write;
        logic [7:0]  brightness_raw;
        logic [6:0]  level_pct;
        logic [1:0]  mode_out;
        logic        button_action;
        logic [6:0]  remembered_pct;
    } t_rsp;

    typedef struct packed {
        logic [15:0] dim_timeout_s;
        logic [15:0] sleep_timeout_s;
        logic        dim_enable;
        logic        sleep_enable;
        logic [6:0]  dim_level_pct;
        logic [15:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [6:0]  saved_pct;
        logic [6:0]  current_pct;
        logic [31:0] last_activity_ms;
        logic [31:0] last_button_ms;
    } t_state;

    function automatic logic [6:0] clamp_pct(input logic [7:0] pct);
        logic [6:0] res;
        if (pct > 8'(PCT_MAX)) begin
            res = PCT_MAX;
        end else begin
            res = pct[6:0];
        end
        return res;
    endfunction

    // pct * 255 / 100 via multiply by reciprocal
    function automatic logic [7:0] pct_to_raw(input logic [6:0] pct);
        logic [27:0] prod;
        prod = 28'(pct) * RAW_RECIP;
        return prod[RAW_SHIFT +: 8];
    endfunction

endpackage

@@ rtl/core/dids_req_if.sv @@
// request channel: valid / ready with the request payload
`timescale 1ns / 1ps

interface dids_req_if;
    logic            valid;
    logic            ready;
    dids_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/dids_rsp_if.sv @@
// result channel: valid / ready with the result payload
`timescale 1ns / 1ps

interface dids_rsp_if;
    logic            valid;
    logic            ready;
    dids_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/dids_step.sv @@
// per-request next state and result logic of the display idle controller
`timescale 1ns / 1ps

module dids_step (
    input  dids_pkg::t_req   i_req,
    input  dids_pkg::t_state i_state,
    input  dids_pkg::t_cfg   i_cfg,
    output dids_pkg::t_state o_state,
    output dids_pkg::t_rsp   o_rsp
);

    logic        dim_on;
    logic        sleep_on;
    logic [31:0] act_diff;
    logic [31:0] btn_diff;
    logic [16:0] sleep_lim_s;
    logic [26:0] sleep_lim_ms;
    logic [25:0] dim_lim_ms;
    logic [6:0]  set_pct;
    logic        wr;
    logic [6:0]  wr_pct;
    logic        action;
    dids_pkg::t_state n_state;

    assign dim_on   = i_cfg.dim_enable && (i_cfg.dim_timeout_s != '0);
    assign sleep_on = i_cfg.sleep_enable && (i_cfg.sleep_timeout_s != '0);
    assign act_diff = i_req.now_ms - i_state.last_activity_ms;
    assign btn_diff = i_req.now_ms - i_state.last_button_ms;

    // idle seconds >= limit  <=>  idle ms >= limit * 1000
    assign sleep_lim_s  = 17'(i_cfg.sleep_timeout_s)
                        + (dim_on ? 17'(i_cfg.dim_timeout_s) : 17'd0);
    assign sleep_lim_ms = 27'(sleep_lim_s) * 27'(dids_pkg::MS_PER_S);
    assign dim_lim_ms   = 26'(i_cfg.dim_timeout_s) * 26'(dids_pkg::MS_PER_S);

    assign set_pct = dids_pkg::clamp_pct(i_req.percent);

    always_comb begin
        n_state = i_state;
        wr      = 1'b0;
        wr_pct  = '0;
        action  = 1'b0;
        case (i_req.req_type)
            dids_pkg::REQ_TICK: begin
                if ((i_state.mode == dids_pkg::MODE_DIMMED && !i_cfg.dim_enable) ||
                    (i_state.mode == dids_pkg::MODE_ASLEEP && !i_cfg.sleep_enable)) begin
                    // feature turned off while in it: restore
                    wr           = 1'b1;
                    wr_pct       = i_state.saved_pct;
                    n_state.mode = dids_pkg::MODE_AWAKE;
                end else if (i_state.mode != dids_pkg::MODE_ASLEEP) begin
                    if (sleep_on && act_diff >= 32'(sleep_lim_ms)) begin
                        wr           = 1'b1;
                        wr_pct       = '0;
                        n_state.mode = dids_pkg::MODE_ASLEEP;
                    end else if (dim_on && i_state.mode == dids_pkg::MODE_AWAKE &&
                                 act_diff >= 32'(dim_lim_ms)) begin
                        wr           = 1'b1;
                        wr_pct       = dids_pkg::clamp_pct({1'b0, i_cfg.dim_level_pct});
                        n_state.mode = dids_pkg::MODE_DIMMED;
                    end
                end
            end
            dids_pkg::REQ_ACTIVITY: begin
                n_state.last_activity_ms = i_req.now_ms;
                if (i_state.mode != dids_pkg::MODE_AWAKE) begin
                    wr           = 1'b1;
                    wr_pct       = i_state.saved_pct;
                    n_state.mode = dids_pkg::MODE_AWAKE;
                end
            end
            dids_pkg::REQ_BUTTON: begin
                if (btn_diff >= 32'(i_cfg.debounce_ms)) begin
                    n_state.last_button_ms   = i_req.now_ms;
                    n_state.last_activity_ms = i_req.now_ms;
                    // action only for a press that did not have to wake
                    action = (i_state.mode == dids_pkg::MODE_AWAKE);
                    if (i_state.mode != dids_pkg::MODE_AWAKE) begin
                        wr           = 1'b1;
                        wr_pct       = i_state.saved_pct;
                        n_state.mode = dids_pkg::MODE_AWAKE;
                    end
                end
            end
            dids_pkg::REQ_SET: begin
                wr     = 1'b1;
                wr_pct = set_pct;
                if (set_pct != '0) begin
                    n_state.saved_pct = set_pct;
                    if (i_state.mode != dids_pkg::MODE_AWAKE) begin
                        n_state.mode             = dids_pkg::MODE_AWAKE;
                        n_state.last_activity_ms = i_req.now_ms;
                    end
                end
            end
            dids_pkg::REQ_OFF: begin
                wr           = 1'b1;
                wr_pct       = '0;
                n_state.mode = dids_pkg::MODE_ASLEEP;
            end
            default: begin
            end
        endcase
        if (wr) begin
            n_state.current_pct = wr_pct;
        end
    end

    assign o_state = n_state;

    always_comb begin
        o_rsp.brightness_write = wr;
        o_rsp.brightness_raw   = wr ? dids_pkg::pct_to_raw(wr_pct) : 8'd0;
        o_rsp.level_pct        = n_state.current_pct;
        o_rsp.mode_out         = n_state.mode;
        o_rsp.button_action    = action;
        o_rsp.remembered_pct   = n_state.saved_pct;
    end

endmodule

@@ rtl/core/display_idle_dim_sleep_controller.sv @@
// Display idle manager with awake, dimmed and asleep states. Requests
// (tick, activity, button, set brightness, turn off) enter through an input
// register, are resolved by one pass of short combinational logic against the
// held state and the configuration registers, and leave through a result
// register. One request is taken every clock cycle while results are not
// stalled. The per-request step logic (a 32-bit timestamp difference
// compared against a timeout times 1000) sets the cycle time. A stalled
// result holds the input register, and a full input register then holds
// off new requests. Configuration is written over the APB-style
// port at byte address 4 * index and should only be written while no request
// is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module display_idle_dim_sleep_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    dids_req_if.sink                      i_req,
    dids_rsp_if.source                    o_rsp,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dids_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    dids_pkg::t_cfg   r_cfg;
    dids_pkg::t_state r_state;
    dids_pkg::t_state n_state;
    dids_pkg::t_req   r_in;
    dids_pkg::t_rsp   r_out;
    dids_pkg::t_rsp   n_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             out_free;
    logic             advance;
    logic             cfg_wr;
    logic [2:0]       reg_idx;

    // ------------------------------------------------------------------
    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[dids_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_timeout_s   <= dids_pkg::RST_DIM_TIMEOUT;
            r_cfg.sleep_timeout_s <= dids_pkg::RST_SLEEP_TIMEOUT;
            r_cfg.dim_enable      <= dids_pkg::RST_DIM_ENABLE;
            r_cfg.sleep_enable    <= dids_pkg::RST_SLEEP_ENABLE;
            r_cfg.dim_level_pct   <= dids_pkg::RST_DIM_LEVEL;
            r_cfg.debounce_ms     <= dids_pkg::RST_DEBOUNCE;
        end else if (cfg_wr) begin
            case (reg_idx)
                dids_pkg::REG_DIM_TIMEOUT:   r_cfg.dim_timeout_s   <= pwdata[15:0];
                dids_pkg::REG_SLEEP_TIMEOUT: r_cfg.sleep_timeout_s <= pwdata[15:0];
                dids_pkg::REG_DIM_ENABLE:    r_cfg.dim_enable      <= pwdata[0];
                dids_pkg::REG_SLEEP_ENABLE:  r_cfg.sleep_enable    <= pwdata[0];
                dids_pkg::REG_DIM_LEVEL:     r_cfg.dim_level_pct   <= pwdata[6:0];
                dids_pkg::REG_DEBOUNCE:      r_cfg.debounce_ms     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dids_pkg::REG_DIM_TIMEOUT:   prdata = 32'(r_cfg.dim_timeout_s);
            dids_pkg::REG_SLEEP_TIMEOUT: prdata = 32'(r_cfg.sleep_timeout_s);
            dids_pkg::REG_DIM_ENABLE:    prdata = 32'(r_cfg.dim_enable);
            dids_pkg::REG_SLEEP_ENABLE:  prdata = 32'(r_cfg.sleep_enable);
            dids_pkg::REG_DIM_LEVEL:     prdata = 32'(r_cfg.dim_level_pct);
            dids_pkg::REG_DEBOUNCE:      prdata = 32'(r_cfg.debounce_ms);
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register -> step logic -> result register
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    dids_step u_step (
        .i_req   (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_rsp   (n_out)
    );

    // display state and brightness bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode             <= dids_pkg::MODE_AWAKE;
            r_state.saved_pct        <= dids_pkg::RST_SAVED_PCT;
            r_state.current_pct      <= '0;
            r_state.last_activity_ms <= '0;
            r_state.last_button_ms   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // ------------------------------------------------------------------
    // assertions
    `DIDS_ASSERT_RST(a_level_range, i_clk, i_rst_n, r_state.current_pct <= dids_pkg::PCT_MAX)
    `DIDS_ASSERT_RST(a_saved_range, i_clk, i_rst_n,
        (r_state.saved_pct != '0) && (r_state.saved_pct <= dids_pkg::PCT_MAX))
    `DIDS_ASSERT_ALWAYS(a_stall_holds_input, i_clk,
        (r_in_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
    `DIDS_ASSERT_RST(a_action_awake, i_clk, i_rst_n,
        (r_out_valid && r_out.button_action) |->
        ((r_out.mode_out == dids_pkg::MODE_AWAKE) && !r_out.brightness_write))
    `DIDS_ASSERT_RST(a_asleep_dark, i_clk, i_rst_n,
        (r_out_valid && r_out.brightness_write && (r_out.mode_out == dids_pkg::MODE_ASLEEP))
        |-> (r_out.brightness_raw == 8'd0))

endmodule
